>>> rtl/pud_pkg.sv
package pud_pkg;

    // ascii codes the decoder cares about
    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
    localparam logic [7:0] CH_DOT   = 8'h2e;  // '.'

    // decoupling queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one classified input byte: up to three output bytes, in order
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } t_ent;

endpackage

>>> rtl/percent_url_decoder_top.sv
// percent-decoding url byte stream
//
// input channel:  i_valid / o_ready, payload i_in_byte, i_in_last (end of string)
// output channel: o_valid / i_ready, payload o_out_byte, o_out_last
// a transfer happens on a rising edge with valid and ready both high
//
// each input byte gives 0 to 3 output bytes; "%xy" with x, y from letters,
// digits, '-' and '.' collapses to one byte, broken escapes pass through
// literally, and an escape open at end of string is flushed as is
//
// an accepted input byte is written into the queue and then loaded into the
// output stage before its first output byte is on offer
// throughput: one input byte per cycle while the four-entry queue has room;
// the output side moves one byte per cycle while i_ready is high, and each
// output byte of an input byte (at most three) needs its own transfer
//
// reset (synchronous, active low) clears the escape state, the queue and
// the output stage; nothing is flushed. when the receiver stalls the output
// byte holds, the queue fills and then o_ready drops
module percent_url_decoder_top import pud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    // front -> queue
    logic push;
    t_ent push_ent;
    logic full;

    // queue -> back
    logic pop;
    logic nempty;
    t_ent head;

    // front: escape tracking and classification of each input byte
    pud_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_full    (full),
        .o_push    (push),
        .o_ent     (push_ent)
    );

    // queue decouples the classifier from the output serializer
    pud_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_ent    (push_ent),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_head   (head)
    );

    // back: sends the bytes of one entry, one transfer per cycle while i_ready is high
    pud_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nempty   (nempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

>>> rtl/pud_front.sv
module pud_front import pud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_full,
    output logic       o_push,
    output t_ent       o_ent
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_FIRST = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic       accept;
    t_ent       ent;

    function automatic logic in_set(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_MINUS || c == CH_DOT;
    endfunction

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9") begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

    function automatic logic [7:0] pair_value(input logic [7:0] c0, input logic [7:0] c1);
        logic [4:0] d0;
        logic [4:0] d1;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        if (c0 == CH_MINUS) begin
            return d1[4] ? (8'h00 - {4'h0, d1[3:0]}) : 8'h00;
        end
        if (d0[4]) begin
            return d1[4] ? {d0[3:0], d1[3:0]} : {4'h0, d0[3:0]};
        end
        return 8'h00;
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = !i_full;

    always_comb begin
        logic consumed;
        ent      = '0;
        n_phase  = r_phase;
        n_first  = r_first;
        consumed = 1'b0;
        unique case (r_phase)
            PH_FIRST: begin
                if (in_set(i_in_byte)) begin
                    ent.bytes[ent.cnt] = pair_value(r_first, i_in_byte);
                    ent.cnt            = ent.cnt + 2'd1;
                    consumed           = 1'b1;
                end else begin
                    ent.bytes[ent.cnt] = CH_PCT;
                    ent.cnt            = ent.cnt + 2'd1;
                    ent.bytes[ent.cnt] = r_first;
                    ent.cnt            = ent.cnt + 2'd1;
                end
                n_phase = PH_IDLE;
                n_first = 8'h00;
            end
            PH_PCT: begin
                if (in_set(i_in_byte)) begin
                    n_first  = i_in_byte;
                    n_phase  = PH_FIRST;
                    consumed = 1'b1;
                end else begin
                    ent.bytes[ent.cnt] = CH_PCT;
                    ent.cnt            = ent.cnt + 2'd1;
                    n_phase            = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (!consumed) begin
            if (i_in_byte == CH_PCT) begin
                n_phase = PH_PCT;
            end else begin
                ent.bytes[ent.cnt] = i_in_byte;
                ent.cnt            = ent.cnt + 2'd1;
            end
        end

        // flush a pending escape at end of string
        if (i_in_last) begin
            if (n_phase == PH_PCT || n_phase == PH_FIRST) begin
                ent.bytes[ent.cnt] = CH_PCT;
                ent.cnt            = ent.cnt + 2'd1;
            end
            if (n_phase == PH_FIRST) begin
                ent.bytes[ent.cnt] = n_first;
                ent.cnt            = ent.cnt + 2'd1;
            end
            n_phase = PH_IDLE;
            n_first = 8'h00;
        end
        ent.last = i_in_last;
    end

    assign o_ent  = ent;
    assign o_push = accept && (ent.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= 8'h00;
        end else if (accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |-> o_push)
        else $error("end of string produced no output entry");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |=> (r_phase == PH_IDLE && r_first == 8'h00))
        else $error("escape state not cleared after end of string");

endmodule

>>> rtl/pud_queue.sv
module pud_queue import pud_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_ent i_ent,
    output logic o_full,
    input  logic i_pop,
    output logic o_nempty,
    output t_ent o_head
);

    t_ent           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full   = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("queue read while empty");

endmodule

>>> rtl/pud_back.sv
module pud_back import pud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_nempty,
    input  t_ent       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    t_ent       r_ent;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       at_end;
    logic       done;

    assign at_end = (r_idx == r_ent.cnt - 2'd1);
    assign done   = r_busy && i_ready && at_end;
    assign o_pop  = i_nempty && (!r_busy || done);

    assign o_valid    = r_busy;
    assign o_out_byte = r_ent.bytes[r_idx];
    assign o_out_last = r_ent.last && at_end;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_ent.cnt))
        else $error("byte index beyond entry count");

endmodule
